// ===== design/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared sizes, configuration register indexes and item types of the
// bilinear resampler.
// ----------------------------------------------------------------------------
package brs_pkg;

    // Block limits
    localparam int MAX_SOURCE_DIM = 256;
    localparam int MAX_TARGET_DIM = 4096;
    localparam int MAX_PLANES     = 3;

    // Fixed field widths
    localparam int COORD_W    = 12;
    localparam int SAMPLE_W   = 16;
    localparam int PLANE_W    = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int SRC_REG_W  = 9;
    localparam int TGT_REG_W  = 13;
    localparam int NP_REG_W   = 2;
    localparam int FRAC_W     = 8;

    // Derived widths
    localparam int SW_W      = $clog2(MAX_SOURCE_DIM + 1);
    localparam int TW_W      = $clog2(MAX_TARGET_DIM + 1);
    localparam int NP_W      = $clog2(MAX_PLANES + 1);
    localparam int SRC_IDX_W = $clog2(MAX_SOURCE_DIM);
    localparam int QW        = SRC_IDX_W + FRAC_W;
    localparam int NUM_W     = COORD_W + 1 + SW_W + FRAC_W;
    localparam int DEN_W     = TW_W + 1;
    localparam int DIV_W     = DEN_W + QW;
    localparam int HALF_W    = (SRC_IDX_W > 1) ? SRC_IDX_W - 1 : 1;
    localparam int RAM_DEPTH = MAX_PLANES << (2 * HALF_W);
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT   = 3'd4;

    // Effective (saturated) frame sizes
    typedef struct packed {
        logic [SW_W-1:0] sw;
        logic [SW_W-1:0] sh;
        logic [TW_W-1:0] tw;
        logic [TW_W-1:0] th;
        logic [NP_W-1:0] np;
    } t_cfg;

    // Classified item as held in the queue
    typedef struct packed {
        logic                is_req;
        logic                ok;
        logic [PLANE_W-1:0]  plane;
        logic [COORD_W-1:0]  col;
        logic [COORD_W-1:0]  row;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

endpackage

// ===== design/brs_ram.sv =====
// ----------------------------------------------------------------------------
// brs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write, then registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/brs_front.sv =====
// ----------------------------------------------------------------------------
// brs_front
// Accepts input items and classifies them as in-range or out-of-range
// loads and requests before they enter the queue.
// ----------------------------------------------------------------------------
module brs_front import brs_pkg::*; (
    input  t_cfg                i_cfg,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic                i_kind,
    input  logic [PLANE_W-1:0]  i_plane,
    input  logic [COORD_W-1:0]  i_column,
    input  logic [COORD_W-1:0]  i_line,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic                i_q_full,
    output logic                o_push,
    output t_item               o_item
);

    logic w_plane_ok;
    logic w_load_ok;
    logic w_req_ok;

    // range checks against the effective sizes
    always_comb begin
        w_plane_ok = 32'(i_plane) < 32'(i_cfg.np);
        w_load_ok  = w_plane_ok && (32'(i_column) < 32'(i_cfg.sw))
                                && (32'(i_line) < 32'(i_cfg.sh));
        w_req_ok   = w_plane_ok && (32'(i_column) < 32'(i_cfg.tw))
                                && (32'(i_line) < 32'(i_cfg.th));
    end

    // build the queue entry
    always_comb begin
        o_item.is_req = i_kind;
        o_item.ok     = i_kind ? w_req_ok : w_load_ok;
        o_item.plane  = i_plane;
        o_item.col    = i_column;
        o_item.row    = i_line;
        o_item.sample = i_sample;
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

endmodule

// ===== design/brs_queue.sv =====
// ----------------------------------------------------------------------------
// brs_queue
// Short item queue between the front and the back.
// ----------------------------------------------------------------------------
module brs_queue import brs_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_item o_item
);

    t_item              r_entry [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr;
    logic [Q_PTR_W-1:0] r_rptr;
    logic [Q_PTR_W:0]   r_count;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= r_count + (Q_PTR_W+1)'(i_push) - (Q_PTR_W+1)'(i_pop);
        end
    end

    // store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wptr] <= i_item;
        end
    end

    assign o_valid = r_count != '0;
    assign o_full  = 32'(r_count) == QUEUE_DEPTH;
    assign o_item  = r_entry[r_rptr];

endmodule

// ===== design/brs_back.sv =====
// ----------------------------------------------------------------------------
// brs_back
// Carries out queued items: position division, neighbour mapping,
// banked frame store access, blend and rounding, output register.
// ----------------------------------------------------------------------------
module brs_back import brs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_valid,
    input  t_item               i_q_item,
    output logic                o_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [SAMPLE_W-1:0] o_pixel,
    output logic                o_range_error
);

    // One restoring division step: shift in a dividend bit, emit a quotient bit
    function automatic logic [DIV_W-1:0] div_step(input logic [DIV_W-1:0] w,
                                                  input logic [DEN_W-1:0] d);
        logic [DEN_W:0]   tr;
        logic [DEN_W-1:0] rem;
        logic             qb;
        tr = {w[DIV_W-1:QW], w[QW-1]};
        if (tr >= {1'b0, d}) begin
            rem = DEN_W'(tr - {1'b0, d});
            qb  = 1'b1;
        end else begin
            rem = tr[DEN_W-1:0];
            qb  = 1'b0;
        end
        return {rem, w[QW-2:0], qb};
    endfunction

    // Frame store address within one parity bank
    function automatic logic [RAM_AW-1:0] ram_addr(input logic [PLANE_W-1:0]   p,
                                                   input logic [SRC_IDX_W-1:0] r,
                                                   input logic [SRC_IDX_W-1:0] c);
        logic [31:0] a;
        a = (32'(p) << (2 * HALF_W)) | ((32'(r) >> 1) << HALF_W) | (32'(c) >> 1);
        return a[RAM_AW-1:0];
    endfunction

    logic en;

    // division pipeline
    logic             r_dv    [QW+1];
    t_item            r_ditem [QW+1];
    logic [DIV_W-1:0] r_wx    [QW+1];
    logic [DIV_W-1:0] r_wy    [QW+1];

    // mapped positions
    logic                 r_m_v;
    t_item                r_m_item;
    logic [SRC_IDX_W-1:0] r_m_x0, r_m_x1, r_m_y0, r_m_y1;
    logic [FRAC_W-1:0]    r_m_fx, r_m_fy;

    // read stage
    logic              r_r_v, r_r_req, r_r_ok;
    logic              r_r_px0, r_r_px1, r_r_py0, r_r_py1;
    logic [FRAC_W-1:0] r_r_fx, r_r_fy;

    // blend stages
    logic               r_p1_v, r_p1_req, r_p1_ok;
    logic [FRAC_W-1:0]  r_p1_fy;
    logic signed [25:0] r_p00, r_p10, r_p01, r_p11;
    logic               r_p2_v, r_p2_req, r_p2_ok;
    logic [FRAC_W-1:0]  r_p2_fy;
    logic signed [26:0] r_h0, r_h1;
    logic               r_p3_v, r_p3_req, r_p3_ok;
    logic signed [36:0] r_a, r_b;

    // output register
    logic                r_o_valid;
    logic [SAMPLE_W-1:0] r_o_pixel;
    logic                r_o_err;

    logic [NUM_W-1:0]     w_nx, w_ny;
    logic [DEN_W-1:0]     w_den_x, w_den_y;
    logic [SRC_IDX_W-1:0] w_x0, w_x1, w_y0, w_y1;
    logic [FRAC_W-1:0]    w_fx, w_fy;
    logic [RAM_AW-1:0]    w_raddr [4];
    logic                 w_we    [4];
    logic [RAM_AW-1:0]    w_waddr;
    logic [SAMPLE_W-1:0]  w_rd    [4];
    logic [FRAC_W:0]      w_wx, w_wy;
    logic signed [37:0]   w_sum;
    logic signed [21:0]   w_r;
    logic [SAMPLE_W-1:0]  w_pix;

    // advance the whole pipeline unless a result waits untaken
    assign en    = !r_o_valid || i_out_ready;
    assign o_pop = en && i_q_valid;

    // numerators and denominators of both axes
    always_comb begin
        w_nx    = (NUM_W'({i_q_item.col, 1'b1}) * NUM_W'(i_cfg.sw)) << FRAC_W;
        w_ny    = (NUM_W'({i_q_item.row, 1'b1}) * NUM_W'(i_cfg.sh)) << FRAC_W;
        w_den_x = {i_cfg.tw, 1'b0};
        w_den_y = {i_cfg.th, 1'b0};
    end

    // floor, clamp and fraction of both axes
    always_comb begin
        logic [QW:0]        bx, by;
        logic [SRC_IDX_W:0] ix, iy;
        logic [SW_W-1:0]    tx, ty;
        bx   = {1'b0, r_wx[QW][QW-1:0]} + (QW+1)'(128);
        by   = {1'b0, r_wy[QW][QW-1:0]} + (QW+1)'(128);
        ix   = bx[QW:FRAC_W];
        iy   = by[QW:FRAC_W];
        tx   = i_cfg.sw - 1'b1;
        ty   = i_cfg.sh - 1'b1;
        w_fx = bx[FRAC_W-1:0];
        w_fy = by[FRAC_W-1:0];
        w_x0 = (ix == '0) ? '0 : SRC_IDX_W'(ix - 1'b1);
        w_y0 = (iy == '0) ? '0 : SRC_IDX_W'(iy - 1'b1);
        w_x1 = (32'(ix) > 32'(tx)) ? SRC_IDX_W'(tx) : SRC_IDX_W'(ix);
        w_y1 = (32'(iy) > 32'(ty)) ? SRC_IDX_W'(ty) : SRC_IDX_W'(iy);
    end

    // bank addressing: bank {row parity, column parity}
    always_comb begin
        logic [SRC_IDX_W-1:0] rs, cs, lr, lc;
        lr      = SRC_IDX_W'(r_m_item.row);
        lc      = SRC_IDX_W'(r_m_item.col);
        w_waddr = ram_addr(r_m_item.plane, lr, lc);
        for (int b = 0; b < 4; b++) begin
            rs = (r_m_y0[0] == b[1]) ? r_m_y0 : r_m_y1;
            cs = (r_m_x0[0] == b[0]) ? r_m_x0 : r_m_x1;
            w_raddr[b] = ram_addr(r_m_item.plane, rs, cs);
            w_we[b]    = en && r_m_v && !r_m_item.is_req && r_m_item.ok
                         && (lr[0] == b[1]) && (lc[0] == b[0]);
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        brs_ram #(
            .WIDTH (SAMPLE_W),
            .DEPTH (RAM_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (w_we[g]),
            .i_waddr (w_waddr),
            .i_wdata (r_m_item.sample),
            .i_re    (en),
            .i_raddr (w_raddr[g]),
            .o_rdata (w_rd[g])
        );
    end

    // weights and final rounding
    always_comb begin
        w_wx  = 9'd256 - {1'b0, r_r_fx};
        w_wy  = 9'd256 - {1'b0, r_p2_fy};
        w_sum = r_a + r_b + 38'sd32768;
        w_r   = 22'(w_sum >>> 16);
        if (w_r > 22'sd32767) begin
            w_pix = 16'h7FFF;
        end else if (w_r < -22'sd32768) begin
            w_pix = 16'h8000;
        end else begin
            w_pix = w_r[SAMPLE_W-1:0];
        end
    end

    // control: valid bits of every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= QW; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_m_v     <= 1'b0;
            r_r_v     <= 1'b0;
            r_p1_v    <= 1'b0;
            r_p2_v    <= 1'b0;
            r_p3_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_dv[0] <= i_q_valid;
            for (int k = 0; k < QW; k++) begin
                r_dv[k+1] <= r_dv[k];
            end
            r_m_v     <= r_dv[QW];
            r_r_v     <= r_m_v;
            r_p1_v    <= r_r_v;
            r_p2_v    <= r_p1_v;
            r_p3_v    <= r_p2_v;
            r_o_valid <= r_p3_v && r_p3_req;
        end
    end

    // payload: hold on stall
    always_ff @(posedge i_clk) begin
        if (en) begin
            // enter division
            r_ditem[0] <= i_q_item;
            r_wx[0]    <= DIV_W'(w_nx);
            r_wy[0]    <= DIV_W'(w_ny);
            for (int k = 0; k < QW; k++) begin
                r_ditem[k+1] <= r_ditem[k];
                r_wx[k+1]    <= div_step(r_wx[k], w_den_x);
                r_wy[k+1]    <= div_step(r_wy[k], w_den_y);
            end
            // map to neighbours
            r_m_item <= r_ditem[QW];
            r_m_x0   <= w_x0;
            r_m_x1   <= w_x1;
            r_m_y0   <= w_y0;
            r_m_y1   <= w_y1;
            r_m_fx   <= w_fx;
            r_m_fy   <= w_fy;
            // store read in flight
            r_r_req  <= r_m_item.is_req;
            r_r_ok   <= r_m_item.ok;
            r_r_px0  <= r_m_x0[0];
            r_r_px1  <= r_m_x1[0];
            r_r_py0  <= r_m_y0[0];
            r_r_py1  <= r_m_y1[0];
            r_r_fx   <= r_m_fx;
            r_r_fy   <= r_m_fy;
            // horizontal products
            r_p1_req <= r_r_req;
            r_p1_ok  <= r_r_ok;
            r_p1_fy  <= r_r_fy;
            r_p00    <= $signed({1'b0, w_wx}) * $signed(w_rd[{r_r_py0, r_r_px0}]);
            r_p10    <= $signed({2'b0, r_r_fx}) * $signed(w_rd[{r_r_py0, r_r_px1}]);
            r_p01    <= $signed({1'b0, w_wx}) * $signed(w_rd[{r_r_py1, r_r_px0}]);
            r_p11    <= $signed({2'b0, r_r_fx}) * $signed(w_rd[{r_r_py1, r_r_px1}]);
            // row sums
            r_p2_req <= r_p1_req;
            r_p2_ok  <= r_p1_ok;
            r_p2_fy  <= r_p1_fy;
            r_h0     <= 27'(r_p00) + 27'(r_p10);
            r_h1     <= 27'(r_p01) + 27'(r_p11);
            // vertical products
            r_p3_req <= r_p2_req;
            r_p3_ok  <= r_p2_ok;
            r_a      <= $signed({1'b0, w_wy}) * r_h0;
            r_b      <= $signed({2'b0, r_p2_fy}) * r_h1;
            // result
            r_o_pixel <= r_p3_ok ? w_pix : '0;
            r_o_err   <= !r_p3_ok;
        end
    end

    assign o_out_valid   = r_o_valid;
    assign o_pixel       = r_o_pixel;
    assign o_range_error = r_o_err;

endmodule

// ===== design/bilinear_image_resampler_core.sv =====
// ----------------------------------------------------------------------------
// bilinear_image_resampler_core
// Planar bilinear scaler with half-pixel centres over a banked frame store.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         i_in_valid / o_in_ready    kind, plane, column, line, sample
//  output    out        o_out_valid / i_out_ready  pixel, range_error
//  config    in         i_cfg_we                   i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while results are taken; a request's result passes
//  through the pipelined 16-step divider, mapping, store read, blend, output stage.
//  Four parity banks give all four neighbours in one store read per cycle.
//  Reset restores the register defaults; the frame store is not cleared.
//  While a result waits untaken the back stalls and the 4-entry queue fills.
// ----------------------------------------------------------------------------
module bilinear_image_resampler_core import brs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic                  i_kind,
    input  logic [PLANE_W-1:0]    i_plane,
    input  logic [COORD_W-1:0]    i_column,
    input  logic [COORD_W-1:0]    i_line,
    input  logic [SAMPLE_W-1:0]   i_sample,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SAMPLE_W-1:0]   o_pixel,
    output logic                  o_range_error
);

    logic [SRC_REG_W-1:0] r_src_w, r_src_h;
    logic [TGT_REG_W-1:0] r_tgt_w, r_tgt_h;
    logic [NP_REG_W-1:0]  r_planes;
    t_cfg                 w_cfg;
    logic                 w_push, w_pop, w_q_valid, w_q_full;
    t_item                w_push_item, w_q_item;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w  <= SRC_REG_W'(256);
            r_src_h  <= SRC_REG_W'(256);
            r_tgt_w  <= TGT_REG_W'(256);
            r_tgt_h  <= TGT_REG_W'(256);
            r_planes <= NP_REG_W'(3);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_src_w  <= i_cfg_data[SRC_REG_W-1:0];
                CFG_SOURCE_HEIGHT: r_src_h  <= i_cfg_data[SRC_REG_W-1:0];
                CFG_TARGET_WIDTH:  r_tgt_w  <= i_cfg_data[TGT_REG_W-1:0];
                CFG_TARGET_HEIGHT: r_tgt_h  <= i_cfg_data[TGT_REG_W-1:0];
                CFG_PLANE_COUNT:   r_planes <= i_cfg_data[NP_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // saturate sizes: zero acts as one, large values clip to the limit
    always_comb begin
        logic [31:0] t;
        t = 32'(r_src_w);
        t = (t == 0) ? 32'd1 : ((t > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : t);
        w_cfg.sw = t[SW_W-1:0];
        t = 32'(r_src_h);
        t = (t == 0) ? 32'd1 : ((t > MAX_SOURCE_DIM) ? MAX_SOURCE_DIM : t);
        w_cfg.sh = t[SW_W-1:0];
        t = 32'(r_tgt_w);
        t = (t == 0) ? 32'd1 : ((t > MAX_TARGET_DIM) ? MAX_TARGET_DIM : t);
        w_cfg.tw = t[TW_W-1:0];
        t = 32'(r_tgt_h);
        t = (t == 0) ? 32'd1 : ((t > MAX_TARGET_DIM) ? MAX_TARGET_DIM : t);
        w_cfg.th = t[TW_W-1:0];
        t = 32'(r_planes);
        t = (t == 0) ? 32'd1 : ((t > MAX_PLANES) ? MAX_PLANES : t);
        w_cfg.np = t[NP_W-1:0];
    end

    brs_front u_front (
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_kind     (i_kind),
        .i_plane    (i_plane),
        .i_column   (i_column),
        .i_line     (i_line),
        .i_sample   (i_sample),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    brs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_item  (w_q_item)
    );

    brs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_q_valid     (w_q_valid),
        .i_q_item      (w_q_item),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel       (o_pixel),
        .o_range_error (o_range_error)
    );

endmodule

// ===== design/brs_checker.sv =====
// ----------------------------------------------------------------------------
// brs_checker
// Port-level checks of the resampler, bound to the top level.
// ----------------------------------------------------------------------------
module brs_checker import brs_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_index,
    input logic [CFG_DATA_W-1:0] i_cfg_data,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  i_kind,
    input logic [PLANE_W-1:0]    i_plane,
    input logic [COORD_W-1:0]    i_column,
    input logic [COORD_W-1:0]    i_line,
    input logic [SAMPLE_W-1:0]   i_sample,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [SAMPLE_W-1:0]   o_pixel,
    input logic                  o_range_error
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_pixel) && $stable(o_range_error))
        else $error("result changed while stalled");

    // flagged results carry a zero pixel
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_range_error |-> o_pixel == '0)
        else $error("range error with non-zero pixel");

    // leave reset empty and ready
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("not idle after reset");

endmodule

bind bilinear_image_resampler_core brs_checker u_brs_checker (.*);
